// ===== rtl/skyb_pkg.sv =====
// Package for the skybox vertex sphere texture coordinate block.
// Holds constants, register indexes, status codes and pipeline stage types.
// No dependencies.
package skyb_pkg;

  localparam int GRID_SIDE = 9;
  localparam int IDX_W     = 9;

  // root bits of the square roots; one root bit is resolved per stage
  localparam int SQ_STEPS  = 31;
  // quotient bits of the texture divides below the overflow limit
  localparam int TX_STEPS  = 15;

  localparam logic [1:0] CFG_EYE_DISTANCE  = 2'd0;
  localparam logic [1:0] CFG_SPHERE_RADIUS = 2'd1;
  localparam logic [1:0] CFG_SCALE_S       = 2'd2;
  localparam logic [1:0] CFG_SCALE_T       = 2'd3;

  localparam logic [15:0] EYE_DISTANCE_RST  = 16'd2304;
  localparam logic [15:0] SPHERE_RADIUS_RST = 16'd2560;
  localparam logic [15:0] SCALE_S_RST       = 16'd1024;
  localparam logic [15:0] SCALE_T_RST       = 16'd1024;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DIR = 2'd1,
    STATUS_MISS     = 2'd2
  } status_e;

  // values that ride along with every beat
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               zero;
    logic               miss;
  } side_t;

  // square root state: remainder and partial root
  typedef struct packed {
    logic [61:0] rem;
    logic [30:0] root;
  } sq_t;

  // restoring divide state
  typedef struct packed {
    logic [62:0] rem;
    logic [30:0] quo;
  } dv_t;

  // saturating texture divide state
  typedef struct packed {
    logic [57:0]          rem;
    logic [TX_STEPS-1:0]  quo;
    logic                 ovf;
  } tx_t;

  typedef struct packed {
    side_t       sd;
    sq_t         sq;
    dv_t         dv;
    logic [31:0] den;
  } s1_t;

  typedef struct packed {
    side_t       sd;
    sq_t         sq;
    dv_t         dv;
    logic [30:0] nrm;
  } s2_t;

  typedef struct packed {
    side_t       sd;
    tx_t         ta;
    tx_t         tb;
    logic [46:0] ds;
    logic [46:0] dt;
    logic        nega;
    logic        negb;
  } s3_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] ts;
    logic signed [15:0] tt;
    status_e            st;
  } out_t;

endpackage

// ===== rtl/skybox_vertex_sphere_texcoord.sv =====
// Top level of the skybox vertex sphere texture coordinate block.
// Depends on skyb_pkg for constants, status codes and stage types.
//
// One grid vertex beat enters per cycle and one result beat leaves per cycle while the
// consumer does not stall. The pipeline is made up of the two chains of 31 single-bit
// square root stages (vertex length, then ray length, each run side by side with a
// 31-stage restoring divide) and the 15-stage saturating divide that forms s and t, plus
// ten arithmetic stages and the output register. The whole pipeline advances together; a
// one-beat skid register behind the output register absorbs the beat in flight when the
// consumer stalls, so in_stall_o is registered and rises only once the skid register is
// full. Configuration registers are read live by the stages and must be written only
// while the block is empty. Status 1 flags a zero vertex, status 2 a ray that misses the
// sphere; both force s and t to zero.
module skybox_vertex_sphere_texcoord
  import skyb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         face_i,
  input  logic [3:0]         row_i,
  input  logic [3:0]         col_i,
  input  logic signed [15:0] origin_x_i,
  input  logic signed [15:0] origin_y_i,
  input  logic signed [15:0] origin_z_i,
  input  logic signed [15:0] row_step_x_i,
  input  logic signed [15:0] row_step_y_i,
  input  logic signed [15:0] row_step_z_i,
  input  logic signed [15:0] col_step_x_i,
  input  logic signed [15:0] col_step_y_i,
  input  logic signed [15:0] col_step_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IDX_W-1:0]   vertex_index_o,
  output logic signed [15:0] vertex_x_o,
  output logic signed [15:0] vertex_y_o,
  output logic signed [15:0] vertex_z_o,
  output logic signed [15:0] tex_s_o,
  output logic signed [15:0] tex_t_o,
  output logic [1:0]         status_o
);

  // ---------------------------------------------------------------------------------------
  // Step functions: one bit of a root or quotient per call
  // ---------------------------------------------------------------------------------------
  function automatic sq_t sq_step(sq_t cur, int k);
    logic [63:0] trial;
    sq_t         nxt;
    trial = ({33'd0, cur.root} << (k + 1)) + (64'd1 << (2 * k));
    nxt   = cur;
    if ({2'd0, cur.rem} >= trial) begin
      nxt.rem  = cur.rem - trial[61:0];
      nxt.root = cur.root | (31'd1 << k);
    end
    return nxt;
  endfunction

  function automatic dv_t dv_step(dv_t cur, logic [31:0] den, int k);
    logic [63:0] sh;
    dv_t         nxt;
    sh  = {32'd0, den} << k;
    nxt = cur;
    if ({1'b0, cur.rem} >= sh) begin
      nxt.rem = cur.rem - sh[62:0];
      nxt.quo = cur.quo | (31'd1 << k);
    end
    return nxt;
  endfunction

  function automatic tx_t tx_step(tx_t cur, logic [46:0] den, int k);
    logic [61:0] sh;
    tx_t         nxt;
    sh  = {15'd0, den} << k;
    nxt = cur;
    if ({4'd0, cur.rem} >= sh) begin
      nxt.rem = cur.rem - sh[57:0];
      nxt.quo = cur.quo | (TX_STEPS'(1) << k);
    end
    return nxt;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [21:0] v);
    logic signed [15:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] tex_fmt(tx_t t, logic neg, logic kill);
    logic signed [15:0] r;
    if (kill) begin
      r = '0;
    end else if (t.ovf) begin
      r = neg ? 16'sh8000 : 16'sh7fff;
    end else if (neg) begin
      r = -$signed({1'b0, t.quo});
    end else begin
      r = $signed({1'b0, t.quo});
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------
  logic [15:0] eye_q, rad_q, scs_q, sct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_q <= EYE_DISTANCE_RST;
      rad_q <= SPHERE_RADIUS_RST;
      scs_q <= SCALE_S_RST;
      sct_q <= SCALE_T_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EYE_DISTANCE:  eye_q <= cfg_wdata_i;
        CFG_SPHERE_RADIUS: rad_q <= cfg_wdata_i;
        CFG_SCALE_S:       scs_q <= cfg_wdata_i;
        CFG_SCALE_T:       sct_q <= cfg_wdata_i;
        default:           eye_q <= eye_q;
      endcase
    end
  end

  // a zero scale acts as one
  logic [15:0] ss, st;
  assign ss = (scs_q == '0) ? 16'd1 : scs_q;
  assign st = (sct_q == '0) ? 16'd1 : sct_q;

  // ---------------------------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless the skid register is occupied
  // ---------------------------------------------------------------------------------------
  logic  out_v_q, skid_v_q;
  out_t  out_q, skid_q;
  logic  en;
  logic  in_acc;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------------------
  // p1: row and column products, flat index
  // ---------------------------------------------------------------------------------------
  logic signed [15:0] org [3];
  logic signed [15:0] rst [3];
  logic signed [15:0] cst [3];

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign rst[0] = row_step_x_i;
  assign rst[1] = row_step_y_i;
  assign rst[2] = row_step_z_i;
  assign cst[0] = col_step_x_i;
  assign cst[1] = col_step_y_i;
  assign cst[2] = col_step_z_i;

  logic               p1_v_q;
  logic [IDX_W-1:0]   p1_idx_q;
  logic signed [15:0] p1_org_q [3];
  logic signed [20:0] p1_pr_q  [3];
  logic signed [20:0] p1_pc_q  [3];
  logic [15:0]        idx_w;

  assign idx_w = 16'(face_i) * 16'(GRID_SIDE * GRID_SIDE) + 16'(row_i) * 16'(GRID_SIDE)
               + 16'(col_i);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_idx_q <= idx_w[IDX_W-1:0];
      for (int a = 0; a < 3; a++) begin
        p1_org_q[a] <= org[a];
        p1_pr_q[a]  <= $signed({1'b0, row_i}) * rst[a];
        p1_pc_q[a]  <= $signed({1'b0, col_i}) * cst[a];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // p2: sum and saturate the position
  // ---------------------------------------------------------------------------------------
  logic               p2_v_q;
  logic [IDX_W-1:0]   p2_idx_q;
  logic signed [15:0] p2_p_q [3];
  logic signed [21:0] psum   [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      psum[a] = 22'(p1_org_q[a]) + 22'(p1_pr_q[a]) + 22'(p1_pc_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_idx_q <= p1_idx_q;
      for (int a = 0; a < 3; a++) begin
        p2_p_q[a] <= sat16(psum[a]);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // p3: squares of each axis
  // ---------------------------------------------------------------------------------------
  logic               p3_v_q;
  logic [IDX_W-1:0]   p3_idx_q;
  logic signed [15:0] p3_p_q  [3];
  logic [30:0]        p3_sq_q [3];
  logic signed [31:0] sqr     [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sqr[a] = p2_p_q[a] * p2_p_q[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_idx_q <= p2_idx_q;
      for (int a = 0; a < 3; a++) begin
        p3_p_q[a]  <= p2_p_q[a];
        p3_sq_q[a] <= sqr[a][30:0];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // p4: squared length and its xy part
  // ---------------------------------------------------------------------------------------
  logic        p4_v_q;
  side_t       p4_sd_q;
  logic [31:0] p4_xy_q, p4_l2_q;
  logic [31:0] xy_w, l2_w;

  assign xy_w = 32'(p3_sq_q[0]) + 32'(p3_sq_q[1]);
  assign l2_w = xy_w + 32'(p3_sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_sd_q.idx  <= p3_idx_q;
      p4_sd_q.x    <= p3_p_q[0];
      p4_sd_q.y    <= p3_p_q[1];
      p4_sd_q.z    <= p3_p_q[2];
      p4_sd_q.zero <= (l2_w == '0);
      p4_sd_q.miss <= 1'b0;
      p4_xy_q      <= xy_w;
      p4_l2_q      <= l2_w;
    end
  end

  // ---------------------------------------------------------------------------------------
  // s1: vertex length root and the xy share of the squared length, side by side
  // ---------------------------------------------------------------------------------------
  s1_t               s1_q [SQ_STEPS];
  s1_t               s1_d [SQ_STEPS];
  logic [SQ_STEPS-1:0] s1_v_q;
  s1_t               s1_init;

  always_comb begin
    s1_init.sd      = p4_sd_q;
    s1_init.sq.rem  = 62'({p4_l2_q, 28'd0});
    s1_init.sq.root = '0;
    s1_init.dv.rem  = 63'({p4_xy_q, 30'd0});
    s1_init.dv.quo  = '0;
    s1_init.den     = p4_l2_q;
    s1_d[0]         = s1_init;
    s1_d[0].sq      = sq_step(s1_init.sq, SQ_STEPS - 1);
    s1_d[0].dv      = dv_step(s1_init.dv, s1_init.den, SQ_STEPS - 1);
    for (int j = 1; j < SQ_STEPS; j++) begin
      s1_d[j]    = s1_q[j-1];
      s1_d[j].sq = sq_step(s1_q[j-1].sq, SQ_STEPS - 1 - j);
      s1_d[j].dv = dv_step(s1_q[j-1].dv, s1_q[j-1].den, SQ_STEPS - 1 - j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // p5..p7: discriminant of the ray against the sphere
  // ---------------------------------------------------------------------------------------
  logic        p5_v_q, p6_v_q, p7_v_q;
  side_t       p5_sd_q, p6_sd_q, p7_sd_q;
  logic [30:0] p5_nrm_q, p6_nrm_q, p7_nrm_q;
  logic [30:0] p5_q_q;
  logic [31:0] p5_bb_q, p5_dd_q, p6_bb_q;
  logic [61:0] p6_ddq_q;
  logic [61:0] p7_disc_q;
  logic [62:0] ddq_w;
  logic signed [62:0] disc_w;

  assign ddq_w  = 63'(p5_dd_q) * 63'(p5_q_q);
  assign disc_w = $signed({1'b0, p6_bb_q, 30'd0}) - $signed({1'b0, p6_ddq_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_sd_q  <= s1_q[SQ_STEPS-1].sd;
      p5_nrm_q <= s1_q[SQ_STEPS-1].sq.root;
      p5_q_q   <= s1_q[SQ_STEPS-1].dv.quo;
      p5_bb_q  <= 32'(rad_q) * 32'(rad_q);
      p5_dd_q  <= 32'(eye_q) * 32'(eye_q);

      p6_sd_q  <= p5_sd_q;
      p6_nrm_q <= p5_nrm_q;
      p6_bb_q  <= p5_bb_q;
      p6_ddq_q <= ddq_w[61:0];

      // carry the side values, flag a negative discriminant as a miss
      p7_sd_q      <= {p6_sd_q.idx, p6_sd_q.x, p6_sd_q.y, p6_sd_q.z, p6_sd_q.zero,
                       disc_w[62]};
      p7_nrm_q     <= p6_nrm_q;
      p7_disc_q    <= disc_w[61:0];
    end
  end

  // ---------------------------------------------------------------------------------------
  // s2: root of the discriminant and the unit z component, side by side
  // ---------------------------------------------------------------------------------------
  s2_t               s2_q [SQ_STEPS];
  s2_t               s2_d [SQ_STEPS];
  logic [SQ_STEPS-1:0] s2_v_q;
  s2_t               s2_init;
  logic [15:0]       absz;

  assign absz = p7_sd_q.z[15] ? 16'(-p7_sd_q.z) : p7_sd_q.z;

  always_comb begin
    s2_init.sd      = p7_sd_q;
    s2_init.sq.rem  = p7_disc_q;
    s2_init.sq.root = '0;
    s2_init.dv.rem  = 63'({absz, 44'd0});
    s2_init.dv.quo  = '0;
    s2_init.nrm     = p7_nrm_q;
    s2_d[0]         = s2_init;
    s2_d[0].sq      = sq_step(s2_init.sq, SQ_STEPS - 1);
    s2_d[0].dv      = dv_step(s2_init.dv, {1'b0, s2_init.nrm}, SQ_STEPS - 1);
    for (int j = 1; j < SQ_STEPS; j++) begin
      s2_d[j]    = s2_q[j-1];
      s2_d[j].sq = sq_step(s2_q[j-1].sq, SQ_STEPS - 1 - j);
      s2_d[j].dv = dv_step(s2_q[j-1].dv, {1'b0, s2_q[j-1].nrm}, SQ_STEPS - 1 - j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // p8..p10: ray length, then numerators and denominators of s and t
  // ---------------------------------------------------------------------------------------
  logic        p8_v_q, p9_v_q, p10_v_q;
  side_t       p8_sd_q, p9_sd_q, p10_sd_q;
  logic [30:0] p8_nrm_q, p9_nrm_q;
  logic [30:0] p8_s_q;
  logic [46:0] p8_m_q;
  logic [31:0] p9_trabs_q;
  logic        p9_trneg_q;
  logic [47:0] p10_na_q, p10_nb_q;
  logic [46:0] p10_ds_q, p10_dt_q;
  logic        p10_nega_q, p10_negb_q;

  logic [31:0]        mag_w;
  logic signed [33:0] tr_w;
  logic [15:0]        absx, absy;

  assign mag_w = p8_m_q[46:15];
  assign tr_w  = p8_sd_q.z[15] ? ($signed({3'b0, p8_s_q}) + $signed({2'b0, mag_w}))
                               : ($signed({3'b0, p8_s_q}) - $signed({2'b0, mag_w}));
  assign absx  = p9_sd_q.x[15] ? 16'(-p9_sd_q.x) : p9_sd_q.x;
  assign absy  = p9_sd_q.y[15] ? 16'(-p9_sd_q.y) : p9_sd_q.y;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p8_sd_q  <= s2_q[SQ_STEPS-1].sd;
      p8_nrm_q <= s2_q[SQ_STEPS-1].nrm;
      p8_s_q   <= s2_q[SQ_STEPS-1].sq.root;
      p8_m_q   <= 47'(eye_q) * 47'(s2_q[SQ_STEPS-1].dv.quo);

      p9_sd_q    <= p8_sd_q;
      p9_nrm_q   <= p8_nrm_q;
      p9_trneg_q <= tr_w[33];
      p9_trabs_q <= tr_w[33] ? 32'(-tr_w) : tr_w[31:0];

      p10_sd_q   <= p9_sd_q;
      p10_na_q   <= 48'(absx) * 48'(p9_trabs_q);
      p10_nb_q   <= 48'(absy) * 48'(p9_trabs_q);
      p10_ds_q   <= 47'(p9_nrm_q) * 47'(ss);
      p10_dt_q   <= 47'(p9_nrm_q) * 47'(st);
      p10_nega_q <= p9_sd_q.x[15] ^ p9_trneg_q;
      p10_negb_q <= p9_sd_q.y[15] ^ p9_trneg_q;
    end
  end

  // ---------------------------------------------------------------------------------------
  // s3: saturating divides for s and t
  // ---------------------------------------------------------------------------------------
  s3_t               s3_q [TX_STEPS];
  s3_t               s3_d [TX_STEPS];
  logic [TX_STEPS-1:0] s3_v_q;
  s3_t               s3_init;

  always_comb begin
    s3_init.sd     = p10_sd_q;
    s3_init.ta.rem = {p10_na_q[46:0], 10'd0, 1'b0} >> 1;
    s3_init.ta.quo = '0;
    s3_init.ta.ovf = 1'b0;
    s3_init.tb.rem = {p10_nb_q[46:0], 10'd0, 1'b0} >> 1;
    s3_init.tb.quo = '0;
    s3_init.tb.ovf = 1'b0;
    s3_init.ds     = p10_ds_q;
    s3_init.dt     = p10_dt_q;
    s3_init.nega   = p10_nega_q;
    s3_init.negb   = p10_negb_q;
    s3_d[0]        = s3_init;
    // flag quotients that reach the positive limit, then take the top bit
    s3_d[0].ta     = tx_step(s3_init.ta, s3_init.ds, TX_STEPS - 1);
    s3_d[0].ta.ovf = {4'd0, s3_init.ta.rem} >= {s3_init.ds, 15'd0};
    s3_d[0].tb     = tx_step(s3_init.tb, s3_init.dt, TX_STEPS - 1);
    s3_d[0].tb.ovf = {4'd0, s3_init.tb.rem} >= {s3_init.dt, 15'd0};
    for (int j = 1; j < TX_STEPS; j++) begin
      s3_d[j]    = s3_q[j-1];
      s3_d[j].ta = tx_step(s3_q[j-1].ta, s3_q[j-1].ds, TX_STEPS - 1 - j);
      s3_d[j].tb = tx_step(s3_q[j-1].tb, s3_q[j-1].dt, TX_STEPS - 1 - j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= s3_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Valid bits, advanced together with the data
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      s1_v_q  <= '0;
      p5_v_q  <= 1'b0;
      p6_v_q  <= 1'b0;
      p7_v_q  <= 1'b0;
      s2_v_q  <= '0;
      p8_v_q  <= 1'b0;
      p9_v_q  <= 1'b0;
      p10_v_q <= 1'b0;
      s3_v_q  <= '0;
    end else if (en) begin
      p1_v_q  <= in_acc;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      p4_v_q  <= p3_v_q;
      s1_v_q  <= {s1_v_q[SQ_STEPS-2:0], p4_v_q};
      p5_v_q  <= s1_v_q[SQ_STEPS-1];
      p6_v_q  <= p5_v_q;
      p7_v_q  <= p6_v_q;
      s2_v_q  <= {s2_v_q[SQ_STEPS-2:0], p7_v_q};
      p8_v_q  <= s2_v_q[SQ_STEPS-1];
      p9_v_q  <= p8_v_q;
      p10_v_q <= p9_v_q;
      s3_v_q  <= {s3_v_q[TX_STEPS-2:0], p10_v_q};
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result formatting, output register and skid register
  // ---------------------------------------------------------------------------------------
  s3_t   last;
  logic  last_v;
  logic  kill;
  out_t  fin;
  logic  out_load;

  assign last   = s3_q[TX_STEPS-1];
  assign last_v = s3_v_q[TX_STEPS-1];
  assign kill   = last.sd.zero || last.sd.miss;

  always_comb begin
    fin.idx = last.sd.idx;
    fin.x   = last.sd.x;
    fin.y   = last.sd.y;
    fin.z   = last.sd.z;
    fin.ts  = tex_fmt(last.ta, last.nega, kill);
    fin.tt  = tex_fmt(last.tb, last.negb, kill);
    if (last.sd.zero) begin
      fin.st = STATUS_ZERO_DIR;
    end else if (last.sd.miss) begin
      fin.st = STATUS_MISS;
    end else begin
      fin.st = STATUS_OK;
    end
  end

  assign out_load = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_load) begin
      // drain the skid beat first; the pipeline is frozen while it is held
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= last_v;
      end
    end else if (en && last_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_v_q ? skid_q : fin;
    end
    if (!out_load && en && last_v) begin
      skid_q <= fin;
    end
  end

  assign out_valid_o    = out_v_q;
  assign vertex_index_o = out_q.idx;
  assign vertex_x_o     = out_q.x;
  assign vertex_y_o     = out_q.y;
  assign vertex_z_o     = out_q.z;
  assign tex_s_o        = out_q.ts;
  assign tex_t_o        = out_q.tt;
  assign status_o       = out_q.st;

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a beat while the output register is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid register filled while the output was free");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> p1_v_q)
    else $error("accepted beat did not enter the pipeline");

  a_error_no_tex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.st != STATUS_OK) |-> (out_q.ts == '0 && out_q.tt == '0))
    else $error("error status with nonzero texture coordinates");

endmodule

// ===== dv/skyb_checker.sv =====
// Checker for the skybox vertex sphere texture coordinate block.
// Watches the configuration port and both beat channels, predicts and compares.
// Depends on skyb_pkg for register indexes, status codes and the result type.
module skyb_checker
  import skyb_pkg::*;
(
  input  logic               clk_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         face_i,
  input  logic [3:0]         row_i,
  input  logic [3:0]         col_i,
  input  logic [47:0]        origin_i,
  input  logic [47:0]        row_step_i,
  input  logic [47:0]        col_step_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_t               result_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 misses_o,
  output int                 zero_dirs_o
);

  logic [15:0] eye_q = EYE_DISTANCE_RST;
  logic [15:0] radius_q = SPHERE_RADIUS_RST;
  logic [15:0] scale_s_q = SCALE_S_RST;
  logic [15:0] scale_t_q = SCALE_T_RST;
  out_t        texcoord_q[$];

  initial begin
    errors_o = 0;
    results_o = 0;
    misses_o = 0;
    zero_dirs_o = 0;
  end

  assign pending_o = texcoord_q.size();

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res = 0;
    longint bit_w = 64'sd1 <<< 62;
    while (bit_w > v) bit_w = bit_w >>> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >>> 1) + bit_w;
      end else begin
        res = res >>> 1;
      end
      bit_w = bit_w >>> 2;
    end
    return res;
  endfunction

  function automatic out_t project_vertex(logic [2:0] face, logic [3:0] row,
                                          logic [3:0] col, logic [47:0] org,
                                          logic [47:0] rs, logic [47:0] cs);
    out_t    r;
    longint  p[3];
    longint  xy, l2, nrm, q, disc, wz, dwz, tr, d, b, ss, st, ts, tt;
    int      idx;
    for (int i = 0; i < 3; i++) begin
      p[i] = sat16(longint'($signed(org[47-16*i -: 16])) +
                   longint'(row) * longint'($signed(rs[47-16*i -: 16])) +
                   longint'(col) * longint'($signed(cs[47-16*i -: 16])));
    end
    ts = 0;
    tt = 0;
    r.st = STATUS_OK;
    xy = p[0] * p[0] + p[1] * p[1];
    l2 = xy + p[2] * p[2];
    if (l2 == 0) begin
      r.st = STATUS_ZERO_DIR;
    end else begin
      d = longint'(eye_q);
      b = longint'(radius_q);
      nrm = int_sqrt(l2 <<< 28);
      q = (xy <<< 30) / l2;
      disc = ((b * b) <<< 30) - d * d * q;
      if (disc < 0) begin
        r.st = STATUS_MISS;
      end else begin
        wz = (p[2] * (64'sd1 <<< 44)) / nrm;
        dwz = (d * wz) / 32768;
        tr = int_sqrt(disc) - dwz;
        // a zero scale counts as one
        ss = (scale_s_q == 0) ? 1 : longint'(scale_s_q);
        st = (scale_t_q == 0) ? 1 : longint'(scale_t_q);
        ts = sat16((p[0] * tr * 1024) / (nrm * ss));
        tt = sat16((p[1] * tr * 1024) / (nrm * st));
      end
    end
    idx = int'(face) * GRID_SIDE * GRID_SIDE + int'(row) * GRID_SIDE + int'(col);
    r.idx = idx[IDX_W-1:0];
    r.x = p[0][15:0];
    r.y = p[1][15:0];
    r.z = p[2][15:0];
    r.ts = ts[15:0];
    r.tt = tt[15:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_t exp_r;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EYE_DISTANCE:  eye_q <= cfg_wdata_i;
        CFG_SPHERE_RADIUS: radius_q <= cfg_wdata_i;
        CFG_SCALE_S:       scale_s_q <= cfg_wdata_i;
        default:           scale_t_q <= cfg_wdata_i;
      endcase
    end
    if (in_valid_i && !in_stall_i) begin
      texcoord_q.push_back(project_vertex(face_i, row_i, col_i, origin_i,
                                          row_step_i, col_step_i));
    end
    if (out_valid_i && !out_stall_i) begin
      results_o++;
      if (texcoord_q.size() == 0) begin
        errors_o++;
        if (errors_o <= 10) $display("unexpected result beat: %p", result_i);
      end else begin
        exp_r = texcoord_q.pop_front();
        if (exp_r.st == STATUS_MISS) misses_o++;
        if (exp_r.st == STATUS_ZERO_DIR) zero_dirs_o++;
        if (result_i.idx !== exp_r.idx || result_i.x !== exp_r.x ||
            result_i.y !== exp_r.y || result_i.z !== exp_r.z ||
            result_i.ts !== exp_r.ts || result_i.tt !== exp_r.tt ||
            result_i.st !== exp_r.st) begin
          errors_o++;
          if (errors_o <= 10) begin
            $display("mismatch idx %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d",
                     exp_r.idx, result_i.idx, exp_r.x, result_i.x,
                     exp_r.y, result_i.y, exp_r.z, result_i.z);
            $display("  s %0d/%0d t %0d/%0d status %0d/%0d (expected/actual)",
                     exp_r.ts, result_i.ts, exp_r.tt, result_i.tt,
                     exp_r.st, result_i.st);
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_skybox_vertex_sphere_texcoord.sv =====
// Testbench top for the skybox vertex sphere texture coordinate block.
// Drives vertex beats, register writes and output stalls; skyb_checker judges.
// Depends on skyb_pkg, skyb_checker and the block itself.
module tb_skybox_vertex_sphere_texcoord;
  import skyb_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  // pipeline depth plus margin, waited out before register writes and at the end
  localparam int DRAIN_CYCLES = 110;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_EYE_DISTANCE;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  face = '0;
  logic [3:0]  row = '0;
  logic [3:0]  col = '0;
  logic [47:0] origin = '0;
  logic [47:0] row_step = '0;
  logic [47:0] col_step = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        result;
  logic [1:0]  status_raw;
  int          errors, pending, results, misses, zero_dirs;
  int          sent = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          stall_on = 1'b0;
  bit          gaps_on = 1'b0;

  always #4 clk = ~clk;

  skybox_vertex_sphere_texcoord DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .face_i        (face),
    .row_i         (row),
    .col_i         (col),
    .origin_x_i    (origin[47:32]),
    .origin_y_i    (origin[31:16]),
    .origin_z_i    (origin[15:0]),
    .row_step_x_i  (row_step[47:32]),
    .row_step_y_i  (row_step[31:16]),
    .row_step_z_i  (row_step[15:0]),
    .col_step_x_i  (col_step[47:32]),
    .col_step_y_i  (col_step[31:16]),
    .col_step_z_i  (col_step[15:0]),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .vertex_index_o(result.idx),
    .vertex_x_o    (result.x),
    .vertex_y_o    (result.y),
    .vertex_z_o    (result.z),
    .tex_s_o       (result.ts),
    .tex_t_o       (result.tt),
    .status_o      (status_raw)
  );

  assign result.st = status_e'(status_raw);

  skyb_checker u_checker (
    .clk_i      (clk),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .face_i     (face),
    .row_i      (row),
    .col_i      (col),
    .origin_i   (origin),
    .row_step_i (row_step),
    .col_step_i (col_step),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .result_i   (result),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results),
    .misses_o   (misses),
    .zero_dirs_o(zero_dirs)
  );

  // Mostly no gap, some short ones, a few long ones.
  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Hold the output stall for random stretches while stalling is on.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_on) begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_left <= gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Count cycles with no beat and no write; bail out if the block hangs.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one vertex beat: optional gap, then hold it until accepted.
  task automatic send_vertex(logic [2:0] f, logic [3:0] r, logic [3:0] c,
                             logic [47:0] o, logic [47:0] rs, logic [47:0] cs);
    int g = gaps_on ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    face <= f;
    row <= r;
    col <= c;
    origin <= o;
    row_step <= rs;
    col_step <= cs;
    in_valid <= 1'b1;
    #1;
    while (in_stall) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [15:0] rand_q(int lo, int hi);
    int v = $urandom_range(0, hi - lo) + lo;
    return v[15:0];
  endfunction

  // Well-formed face grids most of the time, raw noise and degenerate vertices otherwise.
  task automatic send_random_vertex();
    int kind = $urandom_range(0, 99);
    if (kind < 65) begin
      send_vertex(3'($urandom_range(0, 5)), 4'($urandom_range(0, 8)),
                  4'($urandom_range(0, 8)),
                  {rand_q(-16384, 16384), rand_q(-16384, 16384), rand_q(-16384, 16384)},
                  {rand_q(-4096, 4096), rand_q(-4096, 4096), rand_q(-4096, 4096)},
                  {rand_q(-4096, 4096), rand_q(-4096, 4096), rand_q(-4096, 4096)});
    end else if (kind < 72) begin
      send_vertex(3'($urandom_range(0, 7)), 4'd0, 4'd0, 48'd0,
                  48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
    end else begin
      send_vertex(3'($urandom), 4'($urandom), 4'($urandom), 48'({$urandom, $urandom}),
                  48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
    end
  endtask

  // Drop valid and wait until the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] eye, logic [15:0] radius,
                            logic [15:0] sc_s, logic [15:0] sc_t);
    logic [15:0] vals[4];
    vals = '{eye, radius, sc_s, sc_t};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= i[1:0];
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(int count);
    repeat (count) send_random_vertex();
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset registers, no idling.
    send_vertex(3'd0, 4'd0, 4'd0, 48'd0, 48'd0, 48'd0);             // zero direction
    send_vertex(3'd5, 4'd8, 4'd8, {16'hC000, 16'hC000, 16'h4000},
                {16'd0, 16'd2048, 16'd0}, {16'd2048, 16'd0, 16'd0});
    send_vertex(3'd2, 4'd4, 4'd4, {16'h0000, 16'h0000, 16'h4000}, 48'd0, 48'd0);
    send_vertex(3'd3, 4'd1, 4'd1, {16'h0000, 16'h0000, 16'hC000}, 48'd0, 48'd0);
    send_vertex(3'd7, 4'd15, 4'd15, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    send_vertex(3'd6, 4'd15, 4'd15, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    send_vertex(3'd1, 4'd0, 4'd15, {16'h7FFF, 16'h8000, 16'h0001},
                {3{16'hFFFF}}, {16'h0001, 16'h7FFF, 16'h8000});
    send_vertex(3'd4, 4'd9, 4'd12, {16'h4000, 16'h0000, 16'h0000}, 48'd0, 48'd0);
    send_vertex(3'd0, 4'd0, 4'd0, {16'h0000, 16'h0001, 16'h0000}, 48'd0, 48'd0);
    drain();

    // Eye at center, huge sphere, zero scales.
    set_config(16'd0, 16'hFFFF, 16'd0, 16'd0);
    send_vertex(3'd1, 4'd2, 4'd3, {16'h4000, 16'hC000, 16'h2000}, 48'd0, 48'd0);
    send_vertex(3'd2, 4'd0, 4'd0, {16'h7FFF, 16'h7FFF, 16'h0000}, 48'd0, 48'd0);
    send_vertex(3'd3, 4'd0, 4'd0, {16'h0001, 16'h8000, 16'h0000}, 48'd0, 48'd0);
    drain();

    // Far eye, tiny sphere: mostly misses; widest scales.
    set_config(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
    send_vertex(3'd0, 4'd0, 4'd0, {16'h4000, 16'h4000, 16'h4000}, 48'd0, 48'd0);
    send_vertex(3'd0, 4'd0, 4'd0, {16'h0000, 16'h0000, 16'h4000}, 48'd0, 48'd0);
    send_vertex(3'd0, 4'd0, 4'd0, {16'h0000, 16'h0000, 16'hC000}, 48'd0, 48'd0);
    drain();

    // Random phases: several settings, with and without idling.
    set_config(16'd2304, 16'd2560, 16'd1024, 16'd1024);
    gaps_on = 1'b1;
    stall_on = 1'b1;
    random_phase(150);
    // hold off until every result is back, then carry on
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    random_phase(50);
    drain();

    set_config(16'd256, 16'd512, 16'd1, 16'd300);
    gaps_on = 1'b0;
    stall_on = 1'b0;
    random_phase(80);
    drain();

    set_config(rand_q(0, 65535), rand_q(0, 65535), rand_q(1, 65535), rand_q(1, 65535));
    gaps_on = 1'b1;
    stall_on = 1'b1;
    random_phase(100);
    drain();

    set_config(16'd2560, 16'd2304, 16'd128, 16'd4096);
    random_phase(100);
    drain();
    stall_on = 1'b0;
    repeat (4) @(negedge clk);

    $display("sent %0d vertex beats over seven register settings; %0d results checked",
             sent, results);
    $display("zero-direction results %0d, sphere misses %0d", zero_dirs, misses);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
